// ===== sv/ils_pkg.sv =====
package ils_pkg;

  // Storage geometry
  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Read-out tree: cells are ORed in groups, groups are registered
  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_END   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_END    = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_START = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_START  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              put;
    logic              take;
    logic              rd;
    logic [IDX_W-1:0]  tgt;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

  // Count and status of one item
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } item_res_t;

endpackage

// ===== sv/ils_cell.sv =====
module ils_cell
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [WORD_W-1:0] left_d,
  input  logic [WORD_W-1:0] right_d,
  output logic [WORD_W-1:0] q,
  output logic [WORD_W-1:0] rd_q
);

  logic [WORD_W-1:0] ent_r;
  logic [WORD_W-1:0] ent_nxt;

  // Shift up on insert, load at the slot, shift down on removal
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.put && (idx > cmd.tgt)) begin
      ent_nxt = left_d;
    end else if (cmd.put && (idx == cmd.tgt)) begin
      ent_nxt = cmd.value;
    end else if (cmd.take && (idx >= cmd.tgt)) begin
      ent_nxt = right_d;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q    = ent_r;
  // Drive the word onto the read-out tree only when addressed
  assign rd_q = (cmd.rd && (idx == cmd.tgt)) ? ent_r : '0;

endmodule

// ===== sv/ils_ctrl.sv =====
module ils_ctrl
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [OP_W-1:0]   op,
  input  logic [POS_W-1:0]  pos,
  input  logic [WORD_W-1:0] value,
  output cell_cmd_t         cmd,
  output item_res_t         res
);

  logic [CNT_W-1:0]    used_r;
  logic [CNT_W-1:0]    used_nxt;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    posx;
  logic [CMP_W-1:0]    usedx;
  logic                put;
  logic                take;
  logic                rd;
  logic [IDX_W-1:0]    tgt;
  logic [STATUS_W-1:0] status;

  assign full  = (used_r == CNT_W'(DEPTH));
  assign empty = (used_r == '0);
  assign posx  = CMP_W'(pos);
  assign usedx = CMP_W'(used_r);

  // Decode the operation against the current count
  always_comb begin
    put    = 1'b0;
    take   = 1'b0;
    rd     = 1'b0;
    tgt    = '0;
    status = ST_OK;
    case (op)
      OP_PUSH_END: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          put = 1'b1;
          tgt = IDX_W'(used_r);
        end
      end
      OP_PUSH_START: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          put = 1'b1;
        end
      end
      OP_POP_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          take = 1'b1;
          rd   = 1'b1;
          tgt  = IDX_W'(used_r - CNT_W'(1));
        end
      end
      OP_POP_START: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          take = 1'b1;
          rd   = 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (posx > usedx) begin
          status = ST_RANGE;
        end else begin
          put = 1'b1;
          tgt = IDX_W'(pos);
        end
      end
      OP_REMOVE, OP_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (posx >= usedx) begin
          status = ST_RANGE;
        end else begin
          take = (op == OP_REMOVE);
          rd   = 1'b1;
          tgt  = IDX_W'(pos);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Advance the count by the outcome
  always_comb begin
    used_nxt = used_r;
    if (put) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (take) begin
      used_nxt = used_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (acc) begin
      used_r <= used_nxt;
    end
  end

  // Broadcast only on an accepted item
  assign cmd.put   = acc & put;
  assign cmd.take  = acc & take;
  assign cmd.rd    = acc & rd;
  assign cmd.tgt   = tgt;
  assign cmd.value = value;

  assign res.count  = COUNT_W'(used_nxt);
  assign res.status = status;

endmodule

// ===== sv/ils_reduce.sv =====
module ils_reduce
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [WORD_W-1:0] words [DEPTH],
  output logic [WORD_W-1:0] sum
);

  logic [WORD_W-1:0] grp_r   [NGRP];
  logic [WORD_W-1:0] grp_nxt [NGRP];

  // OR each group of cells; only the addressed cell is nonzero
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | words[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Merge the registered groups
  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = sum | grp_r[g];
    end
  end

endmodule

// ===== sv/indexed_list_store_top.sv =====
// Indexed list store: an ordered list of up to 64 words held in a chain of cells, one word
// per cell. Push and pop at either end, insert, remove and read at a position act on the
// chain at once: every cell from the addressed slot onward shifts toward its neighbor, and a
// read shifts none. The block accepts one item per cycle while in_stall is low. The
// addressed word passes through a two-level registered OR tree; each result moves from
// the tree stage into the result register. The result register and the tree stage hold
// items while out_stall is high, and in_stall rises once both are full.
module indexed_list_store_top
  import ils_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [POS_W-1:0]    in_pos,
  input  logic [WORD_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_value_res,
  output logic [COUNT_W-1:0]  out_count,
  output logic [STATUS_W-1:0] out_status
);

  logic              acc;
  logic              b_free;
  logic              a_adv;
  logic              a_valid_r;
  logic              a_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  cell_cmd_t         cmd;
  item_res_t         res;
  item_res_t         a_res_r;
  item_res_t         out_res_r;
  logic [WORD_W-1:0] out_value_r;
  logic [WORD_W-1:0] tree_sum;
  logic [WORD_W-1:0] q     [DEPTH];
  logic [WORD_W-1:0] rd_q  [DEPTH];

  // Handshake: tree stage advances when the result register frees up
  assign b_free   = !out_valid_r || !out_stall;
  assign a_adv    = a_valid_r && b_free;
  assign in_stall = a_valid_r && !b_free;
  assign acc      = in_valid && !in_stall;

  ils_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .op    (in_op),
    .pos   (in_pos),
    .value (in_value),
    .cmd   (cmd),
    .res   (res)
  );

  // Chain of cells; the ends feed back their own word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_d;
    logic [WORD_W-1:0] right_d;
    assign left_d  = (i == 0) ? q[i] : q[(i == 0) ? 0 : i - 1];
    assign right_d = (i == DEPTH - 1) ? q[i] : q[(i == DEPTH - 1) ? i : i + 1];
    ils_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .cmd     (cmd),
      .left_d  (left_d),
      .right_d (right_d),
      .q       (q[i]),
      .rd_q    (rd_q[i])
    );
  end

  ils_reduce u_reduce (
    .clk   (clk),
    .load  (acc),
    .words (rd_q),
    .sum   (tree_sum)
  );

  // Valid bits of the tree stage and the result register
  always_comb begin
    a_valid_nxt   = acc || (a_valid_r && !a_adv);
    out_valid_nxt = b_free ? a_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (acc) begin
      a_res_r <= res;
    end
    if (a_adv) begin
      out_res_r   <= a_res_r;
      out_value_r <= tree_sum;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_count     = out_res_r.count;
  assign out_status    = out_res_r.status;

endmodule

// ===== sv/ils_chk.sv =====
module ils_chk
  import ils_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [WORD_W-1:0]   out_value_res,
  input  logic [COUNT_W-1:0]  out_count,
  input  logic [STATUS_W-1:0] out_status
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_res) &&
      $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

  // Reset drops the result channel
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Refused items carry no word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value_res == '0)
    else $error("nonzero word on refused item");

  // Full status only at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(DEPTH))
    else $error("full status below capacity");

  // Empty status only with no entries
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with entries");

endmodule

bind indexed_list_store_top ils_chk u_ils_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_res (out_value_res),
  .out_count     (out_count),
  .out_status    (out_status)
);
